[design/des_pkg.sv]
package des_pkg;

    localparam int BLOCK_W = 64;
    localparam int HALF_W  = 32;
    localparam int SUBKEY_W = 48;
    localparam int CD_W    = 56;
    localparam int HALF28_W = 28;
    localparam int CFG_IDX_W = 1;
    localparam logic [63:0] KEY_RESET = 64'hAABB09182736CCDD;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR = 1'b1;

    typedef logic [HALF28_W-1:0] t_half28;

    typedef logic [5:0] t_tab64 [64];
    typedef logic [5:0] t_tab48 [48];
    typedef logic [5:0] t_tab56 [56];
    typedef logic [4:0] t_tab32 [32];
    typedef logic [3:0] t_sbox [8][64];

    localparam t_tab64 TAB_IP = '{
        6'd57,6'd49,6'd41,6'd33,6'd25,6'd17,6'd9,6'd1,
        6'd59,6'd51,6'd43,6'd35,6'd27,6'd19,6'd11,6'd3,
        6'd61,6'd53,6'd45,6'd37,6'd29,6'd21,6'd13,6'd5,
        6'd63,6'd55,6'd47,6'd39,6'd31,6'd23,6'd15,6'd7,
        6'd56,6'd48,6'd40,6'd32,6'd24,6'd16,6'd8,6'd0,
        6'd58,6'd50,6'd42,6'd34,6'd26,6'd18,6'd10,6'd2,
        6'd60,6'd52,6'd44,6'd36,6'd28,6'd20,6'd12,6'd4,
        6'd62,6'd54,6'd46,6'd38,6'd30,6'd22,6'd14,6'd6};

    localparam t_tab64 TAB_FP = '{
        6'd39,6'd7,6'd47,6'd15,6'd55,6'd23,6'd63,6'd31,
        6'd38,6'd6,6'd46,6'd14,6'd54,6'd22,6'd62,6'd30,
        6'd37,6'd5,6'd45,6'd13,6'd53,6'd21,6'd61,6'd29,
        6'd36,6'd4,6'd44,6'd12,6'd52,6'd20,6'd60,6'd28,
        6'd35,6'd3,6'd43,6'd11,6'd51,6'd19,6'd59,6'd27,
        6'd34,6'd2,6'd42,6'd10,6'd50,6'd18,6'd58,6'd26,
        6'd33,6'd1,6'd41,6'd9,6'd49,6'd17,6'd57,6'd25,
        6'd32,6'd0,6'd40,6'd8,6'd48,6'd16,6'd56,6'd24};

    localparam t_tab48 TAB_E = '{
        6'd31,6'd0,6'd1,6'd2,6'd3,6'd4,6'd3,6'd4,
        6'd5,6'd6,6'd7,6'd8,6'd7,6'd8,6'd9,6'd10,
        6'd11,6'd12,6'd11,6'd12,6'd13,6'd14,6'd15,6'd16,
        6'd15,6'd16,6'd17,6'd18,6'd19,6'd20,6'd19,6'd20,
        6'd21,6'd22,6'd23,6'd24,6'd23,6'd24,6'd25,6'd26,
        6'd27,6'd28,6'd27,6'd28,6'd29,6'd30,6'd31,6'd0};

    localparam t_tab32 TAB_P = '{
        5'd15,5'd6,5'd19,5'd20,5'd28,5'd11,5'd27,5'd16,
        5'd0,5'd14,5'd22,5'd25,5'd4,5'd17,5'd30,5'd9,
        5'd1,5'd7,5'd23,5'd13,5'd31,5'd26,5'd2,5'd8,
        5'd18,5'd12,5'd29,5'd5,5'd21,5'd10,5'd3,5'd24};

    localparam t_tab56 TAB_PC1 = '{
        6'd56,6'd48,6'd40,6'd32,6'd24,6'd16,6'd8,
        6'd0,6'd57,6'd49,6'd41,6'd33,6'd25,6'd17,
        6'd9,6'd1,6'd58,6'd50,6'd42,6'd34,6'd26,
        6'd18,6'd10,6'd2,6'd59,6'd51,6'd43,6'd35,
        6'd62,6'd54,6'd46,6'd38,6'd30,6'd22,6'd14,
        6'd6,6'd61,6'd53,6'd45,6'd37,6'd29,6'd21,
        6'd13,6'd5,6'd60,6'd52,6'd44,6'd36,6'd28,
        6'd20,6'd12,6'd4,6'd27,6'd19,6'd11,6'd3};

    localparam t_tab48 TAB_PC2 = '{
        6'd13,6'd16,6'd10,6'd23,6'd0,6'd4,6'd2,6'd27,
        6'd14,6'd5,6'd20,6'd9,6'd22,6'd18,6'd11,6'd3,
        6'd25,6'd7,6'd15,6'd6,6'd26,6'd19,6'd12,6'd1,
        6'd40,6'd51,6'd30,6'd36,6'd46,6'd54,6'd29,6'd39,
        6'd50,6'd44,6'd32,6'd47,6'd43,6'd48,6'd38,6'd55,
        6'd33,6'd52,6'd45,6'd41,6'd49,6'd35,6'd28,6'd31};

    // per round: 1 means rotate by one, else by two
    localparam logic [15:0] ROT_ONE = 16'b1000_0001_0000_0011;

    localparam t_sbox SBOX = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

    // tables hold zero-based positions counted from the msb
    function automatic logic [63:0] perm64(input logic [63:0] v, input t_tab64 t);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[63-t[i]];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[63-TAB_PC1[i]];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[55-TAB_PC2[i]];
        return r;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] rv, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [5:0]  b;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) x[47-i] = rv[31-TAB_E[i]];
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            b = x[47-6*i -: 6];
            s[31-4*i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[31-TAB_P[i]];
        return p;
    endfunction

    function automatic t_half28 rot28(input t_half28 x, input logic one);
        return one ? {x[26:0], x[27]} : {x[25:0], x[27:26]};
    endfunction

    function automatic t_half28 rotr28(input t_half28 x, input logic one);
        return one ? {x[0], x[27:1]} : {x[1:0], x[27:2]};
    endfunction

endpackage

[design/des_round_cell.sv]
module des_round_cell import des_pkg::*; #(
    parameter int ROUND = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_l,
    input  logic [31:0]   i_r,
    input  logic [55:0]   i_cd,
    input  logic          i_dir,
    output logic          o_valid,
    output logic [31:0]   o_l,
    output logic [31:0]   o_r,
    output logic [55:0]   o_cd,
    output logic          o_dir
);
    // encrypt rotates left before use, decrypt uses then rotates right
    localparam logic ROT_ENC = ROT_ONE[ROUND];
    localparam logic ROT_DEC = ROT_ONE[15-ROUND];

    logic [55:0] w_cd_enc;
    logic [55:0] w_cd_use;
    logic [55:0] n_cd;

    logic        r_valid;
    logic [31:0] r_l, r_r;
    logic [55:0] r_cd;
    logic        r_dir;

    assign w_cd_enc = {rot28(i_cd[55:28], ROT_ENC), rot28(i_cd[27:0], ROT_ENC)};
    assign w_cd_use = i_dir ? i_cd : w_cd_enc;
    assign n_cd = i_dir ? {rotr28(i_cd[55:28], ROT_DEC), rotr28(i_cd[27:0], ROT_DEC)}
                        : w_cd_enc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_l   <= i_r;
        r_r   <= i_l ^ feistel(i_r, perm_pc2(w_cd_use));
        r_cd  <= n_cd;
        r_dir <= i_dir;
    end

    assign o_valid = r_valid;
    assign o_l     = r_l;
    assign o_r     = r_r;
    assign o_cd    = r_cd;
    assign o_dir   = r_dir;
endmodule

[design/des_block_cipher.sv]
// pipeline from start to o_done: input stage, 16 round cells, output stage
// throughput: one block per cycle, i_start may be high every cycle
// each round cell carries its own key schedule state alongside the block
// reset clears the valid chain, key to AABB09182736CCDD and direction to decrypt
// the receiver cannot stall: o_done is high for one cycle per result
module des_block_cipher import des_pkg::*; #(
    parameter int ROUND_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [63:0] i_data_block,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_done,
    output logic [63:0] o_result_block
);
    logic [63:0] r_key;
    logic        r_dir;

    logic        r_in_valid;
    logic [31:0] r_in_l, r_in_r;
    logic [55:0] r_in_cd;
    logic        r_in_dir;

    logic        w_valid [ROUND_COUNT+1];
    logic [31:0] w_l     [ROUND_COUNT+1];
    logic [31:0] w_r     [ROUND_COUNT+1];
    logic [55:0] w_cd    [ROUND_COUNT+1];
    logic        w_dir   [ROUND_COUNT+1];

    logic [63:0] w_ip;
    logic        r_done;
    logic [63:0] r_result;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_RESET;
            r_dir <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY: r_key <= i_cfg_data;
                CFG_DIR: r_dir <= i_cfg_data[0];
                default: r_dir <= r_dir;
            endcase
        end
    end

    assign w_ip = perm64(i_data_block, TAB_IP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start;
        end
        r_in_l   <= w_ip[63:32];
        r_in_r   <= w_ip[31:0];
        r_in_cd  <= perm_pc1(r_key);
        r_in_dir <= r_dir;
    end

    assign w_valid[0] = r_in_valid;
    assign w_l[0]     = r_in_l;
    assign w_r[0]     = r_in_r;
    assign w_cd[0]    = r_in_cd;
    assign w_dir[0]   = r_in_dir;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        des_round_cell #(.ROUND(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_l     (w_l[g]),
            .i_r     (w_r[g]),
            .i_cd    (w_cd[g]),
            .i_dir   (w_dir[g]),
            .o_valid (w_valid[g+1]),
            .o_l     (w_l[g+1]),
            .o_r     (w_r[g+1]),
            .o_cd    (w_cd[g+1]),
            .o_dir   (w_dir[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_valid[ROUND_COUNT];
        end
        r_result <= perm64({w_r[ROUND_COUNT], w_l[ROUND_COUNT]}, TAB_FP);
    end

    assign o_done         = r_done;
    assign o_result_block = r_result;
endmodule

[design/des_checker.sv]
module des_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_cfg_ready,
    input logic        o_done
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("cfg not ready");
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##18 o_done)
        else $error("result missing");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(i_start, 18) && $past(i_rst_n, 19)) |-> !o_done)
        else $error("unexpected result");
endmodule

bind des_block_cipher des_checker u_des_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_cfg_ready (o_cfg_ready),
    .o_done      (o_done)
);
